>>> rtl/core/tda_pkg.sv
// ----------------------------------------------------------------------------
// tda_pkg
// Shared types, opcodes and hash constants for the tuple id assigner.
// ----------------------------------------------------------------------------
package tda_pkg;

	localparam logic [31:0] NULL_PATTERN = 32'h8000_0000;
	localparam logic [63:0] HASH_MUL_A   = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] HASH_MUL_B   = 64'hBF58_476D_1CE4_E5B9;

	// configuration register indexes
	localparam logic CFG_LAYERS_IN_USE = 1'b0;
	localparam logic CFG_REQUIRE_ALL   = 1'b1;

	typedef struct packed {
		logic signed [31:0] cat_3;
		logic signed [31:0] cat_2;
		logic signed [31:0] cat_1;
		logic signed [31:0] cat_0;
	} cat_in_t;

	typedef struct packed {
		logic [9:0]  tuple_id;
		logic        is_null;
		logic        is_new;
		logic        overflow;
		logic [10:0] ids_used;
	} id_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_CHECK, ST_M1B, ST_M1C, ST_MIX, ST_M2A, ST_M2B,
		ST_M2C, ST_FOLD, ST_MOD, ST_READ, ST_CMP
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_M1A, OP_M1B, OP_M1C, OP_MIX, OP_M2A,
		OP_M2B, OP_M2C, OP_FOLD, OP_MOD, OP_READ, OP_STEP, OP_HIT,
		OP_INSERT, OP_OVFL, OP_NULL
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic null_item;
		logic clr_done;
		logic mod_done;
		logic rd_valid;
		logic rd_match;
		logic table_full;
		logic probe_last;
	} status_t;

endpackage

>>> rtl/core/tda_ctrl.sv
// ----------------------------------------------------------------------------
// tda_ctrl
// Sequencer: table clear, hash steps, probe loop and result selection.
// ----------------------------------------------------------------------------
module tda_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tda_pkg::status_t status,
	output tda_pkg::cmd_t    cmd
);

	tda_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tda_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = tda_pkg::OP_NONE;
		busy    = (state_q != tda_pkg::ST_IDLE);
		case (state_q)
			tda_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op  = tda_pkg::OP_LOAD;
					state_d = tda_pkg::ST_CHECK;
				end
			end
			tda_pkg::ST_CLEAR: begin
				cmd.op = tda_pkg::OP_CLR;
				if (status.clr_done) state_d = tda_pkg::ST_IDLE;
			end
			tda_pkg::ST_CHECK: begin
				if (status.null_item) begin
					cmd.op  = tda_pkg::OP_NULL;
					state_d = tda_pkg::ST_IDLE;
				end else begin
					cmd.op  = tda_pkg::OP_M1A;
					state_d = tda_pkg::ST_M1B;
				end
			end
			tda_pkg::ST_M1B: begin
				cmd.op  = tda_pkg::OP_M1B;
				state_d = tda_pkg::ST_M1C;
			end
			tda_pkg::ST_M1C: begin
				cmd.op  = tda_pkg::OP_M1C;
				state_d = tda_pkg::ST_MIX;
			end
			tda_pkg::ST_MIX: begin
				cmd.op  = tda_pkg::OP_MIX;
				state_d = tda_pkg::ST_M2A;
			end
			tda_pkg::ST_M2A: begin
				cmd.op  = tda_pkg::OP_M2A;
				state_d = tda_pkg::ST_M2B;
			end
			tda_pkg::ST_M2B: begin
				cmd.op  = tda_pkg::OP_M2B;
				state_d = tda_pkg::ST_M2C;
			end
			tda_pkg::ST_M2C: begin
				cmd.op  = tda_pkg::OP_M2C;
				state_d = tda_pkg::ST_FOLD;
			end
			tda_pkg::ST_FOLD: begin
				cmd.op  = tda_pkg::OP_FOLD;
				state_d = tda_pkg::ST_MOD;
			end
			tda_pkg::ST_MOD: begin
				cmd.op = tda_pkg::OP_MOD;
				if (status.mod_done) state_d = tda_pkg::ST_READ;
			end
			tda_pkg::ST_READ: begin
				cmd.op  = tda_pkg::OP_READ;
				state_d = tda_pkg::ST_CMP;
			end
			tda_pkg::ST_CMP: begin
				state_d = tda_pkg::ST_IDLE;
				if (!status.rd_valid) begin
					cmd.op = status.table_full ? tda_pkg::OP_OVFL : tda_pkg::OP_INSERT;
				end else if (status.rd_match) begin
					cmd.op = tda_pkg::OP_HIT;
				end else if (status.probe_last) begin
					cmd.op = tda_pkg::OP_OVFL;
				end else begin
					cmd.op  = tda_pkg::OP_STEP;
					state_d = tda_pkg::ST_READ;
				end
			end
			default: begin
				state_d = tda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/tda_dp.sv
// ----------------------------------------------------------------------------
// tda_dp
// Datapath: key capture, two-stage multiplicative hash on one shared 32x32
// multiplier, slot reduction, slot memory and result register.
// ----------------------------------------------------------------------------
module tda_dp #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int MAX_LAYERS    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tda_pkg::cmd_t    cmd,
	output tda_pkg::status_t status,
	input  tda_pkg::cat_in_t cat,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [2:0]       cfg_data,
	output logic             done,
	output tda_pkg::id_out_t result
);

	localparam int  IDX_W = $clog2(TABLE_ENTRIES);
	localparam int  NID_W = IDX_W + 1;
	localparam int  ENT_W = 1 + 128 + IDX_W;
	localparam bit  POW2  = ((1 << IDX_W) == TABLE_ENTRIES);

	// slot reduction constants: 2^32 mod size and floor(2^32 / size)
	localparam logic [31:0] MOD_R32   = 32'((64'd1 << 32) % 64'(TABLE_ENTRIES));
	localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));

	// slot reduction phases
	localparam logic [1:0] MPH_FOLD = 2'd0;
	localparam logic [1:0] MPH_EST  = 2'd1;
	localparam logic [1:0] MPH_BACK = 2'd2;
	localparam logic [1:0] MPH_FIX  = 2'd3;

	logic [2:0]       layers_q;
	logic             req_all_q;
	logic [63:0]      key_lo_q, key_hi_q;
	logic             null_q;
	logic [63:0]      acc_q, x_q, mod_v_q;
	logic [31:0]      mod_q_q;
	logic [1:0]       mod_ph_q;
	logic [IDX_W-1:0] idx_q, probe_q, clr_q;
	logic [NID_W-1:0] next_id_q;
	logic [ENT_W-1:0] mem [TABLE_ENTRIES];
	logic [ENT_W-1:0] rd_q;
	logic             done_q;
	tda_pkg::id_out_t result_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layers_q  <= 3'd4;
			req_all_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tda_pkg::CFG_LAYERS_IN_USE: layers_q  <= cfg_data;
				tda_pkg::CFG_REQUIRE_ALL:   req_all_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key masking and null test
	logic [2:0]  n_use;
	logic [31:0] lane [4];
	logic        any_null, any_val, null_d;
	always_comb begin
		if (layers_q == 3'd0) n_use = 3'd1;
		else if (layers_q > 3'(MAX_LAYERS)) n_use = 3'(MAX_LAYERS);
		else n_use = layers_q;
		lane[0] = (3'd0 < n_use) ? cat.cat_0 : 32'd0;
		lane[1] = (3'd1 < n_use) ? cat.cat_1 : 32'd0;
		lane[2] = (3'd2 < n_use) ? cat.cat_2 : 32'd0;
		lane[3] = (3'd3 < n_use) ? cat.cat_3 : 32'd0;
		any_null = 1'b0;
		any_val  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < n_use) begin
				if (lane[i] == tda_pkg::NULL_PATTERN) any_null = 1'b1;
				else any_val = 1'b1;
			end
		end
		null_d = req_all_q ? any_null : !any_val;
	end

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod, mix_t, fold;
	logic [31:0] mod_r, mod_fix;
	always_comb begin
		mul_a = key_lo_q[31:0];
		mul_b = tda_pkg::HASH_MUL_A[31:0];
		case (cmd.op)
			tda_pkg::OP_M1B: mul_b = tda_pkg::HASH_MUL_A[63:32];
			tda_pkg::OP_M1C: mul_a = key_lo_q[63:32];
			tda_pkg::OP_M2A: begin
				mul_a = x_q[31:0];
				mul_b = tda_pkg::HASH_MUL_B[31:0];
			end
			tda_pkg::OP_M2B: begin
				mul_a = x_q[31:0];
				mul_b = tda_pkg::HASH_MUL_B[63:32];
			end
			tda_pkg::OP_M2C: begin
				mul_a = x_q[63:32];
				mul_b = tda_pkg::HASH_MUL_B[31:0];
			end
			tda_pkg::OP_MOD: begin
				case (mod_ph_q)
					MPH_FOLD: begin
						mul_a = mod_v_q[63:32];
						mul_b = MOD_R32;
					end
					MPH_EST: begin
						mul_a = mod_v_q[31:0];
						mul_b = MOD_RECIP;
					end
					default: begin
						mul_a = mod_q_q;
						mul_b = 32'(TABLE_ENTRIES);
					end
				endcase
			end
			default: ;
		endcase
		prod    = 64'(mul_a) * 64'(mul_b);
		mix_t   = acc_q ^ key_hi_q;
		fold    = acc_q ^ (acc_q >> 32);
		// quotient estimate is low by at most one, so one subtract finishes
		mod_r   = mod_v_q[31:0] - prod[31:0];
		mod_fix = (mod_v_q[31:0] >= 32'(TABLE_ENTRIES))
			? mod_v_q[31:0] - 32'(TABLE_ENTRIES) : mod_v_q[31:0];
	end

	// hash and probe registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			tda_pkg::OP_LOAD: begin
				key_lo_q <= {lane[1], lane[0]};
				key_hi_q <= {lane[3], lane[2]};
				null_q   <= null_d;
			end
			tda_pkg::OP_M1A, tda_pkg::OP_M2A: acc_q <= prod;
			tda_pkg::OP_M1B, tda_pkg::OP_M1C, tda_pkg::OP_M2B, tda_pkg::OP_M2C:
				acc_q <= acc_q + (prod << 32);
			tda_pkg::OP_MIX: x_q <= mix_t ^ (mix_t >> 29);
			tda_pkg::OP_FOLD: begin
				idx_q    <= fold[IDX_W-1:0];
				mod_v_q  <= fold;
				mod_ph_q <= MPH_FOLD;
				probe_q  <= '0;
			end
			tda_pkg::OP_MOD: begin
				if (!POW2) begin
					case (mod_ph_q)
						// fold the upper word down with 2^32 mod size
						MPH_FOLD: begin
							if (mod_v_q[63:32] != 32'd0) mod_v_q <= prod + 64'(mod_v_q[31:0]);
							else mod_ph_q <= MPH_EST;
						end
						MPH_EST: begin
							mod_q_q  <= prod[63:32];
							mod_ph_q <= MPH_BACK;
						end
						MPH_BACK: begin
							mod_v_q  <= 64'(mod_r);
							mod_ph_q <= MPH_FIX;
						end
						default: idx_q <= mod_fix[IDX_W-1:0];
					endcase
				end
			end
			tda_pkg::OP_STEP: begin
				idx_q   <= (idx_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
			default: ;
		endcase
	end

	// clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == tda_pkg::OP_CLR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// slot memory: {valid, key_hi, key_lo, id}
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [ENT_W-1:0] mem_wd;
	always_comb begin
		mem_we = (cmd.op == tda_pkg::OP_CLR) || (cmd.op == tda_pkg::OP_INSERT);
		mem_wa = (cmd.op == tda_pkg::OP_CLR) ? clr_q : idx_q;
		mem_wd = (cmd.op == tda_pkg::OP_CLR) ? '0
			: {1'b1, key_hi_q, key_lo_q, next_id_q[IDX_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == tda_pkg::OP_READ) rd_q <= mem[idx_q];
	end

	// results
	logic [31:0] hit_id, new_id, ids_after;
	always_comb begin
		hit_id    = 32'(rd_q[IDX_W-1:0]);
		new_id    = 32'(next_id_q);
		ids_after = 32'(next_id_q) + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (cmd.op == tda_pkg::OP_HIT) || (cmd.op == tda_pkg::OP_INSERT)
				|| (cmd.op == tda_pkg::OP_OVFL) || (cmd.op == tda_pkg::OP_NULL);
			if (cmd.op == tda_pkg::OP_INSERT) next_id_q <= next_id_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		result_q.is_null  <= (cmd.op == tda_pkg::OP_NULL);
		result_q.is_new   <= (cmd.op == tda_pkg::OP_INSERT);
		result_q.overflow <= (cmd.op == tda_pkg::OP_OVFL);
		result_q.ids_used <= (cmd.op == tda_pkg::OP_INSERT) ? ids_after[10:0] : new_id[10:0];
		result_q.tuple_id <= (cmd.op == tda_pkg::OP_HIT) ? hit_id[9:0]
			: (cmd.op == tda_pkg::OP_INSERT) ? new_id[9:0] : 10'd0;
	end

	assign done   = done_q;
	assign result = result_q;

	assign status.null_item  = null_q;
	assign status.clr_done   = (clr_q == IDX_W'(TABLE_ENTRIES - 1));
	assign status.mod_done   = POW2 || (mod_ph_q == MPH_FIX);
	assign status.rd_valid   = rd_q[ENT_W-1];
	assign status.rd_match   = (rd_q[ENT_W-2:IDX_W] == {key_hi_q, key_lo_q});
	assign status.table_full = (next_id_q == NID_W'(TABLE_ENTRIES));
	assign status.probe_last = (probe_q == IDX_W'(TABLE_ENTRIES - 1));

endmodule

>>> rtl/core/tuple_dictionary_id_assigner_unit.sv
// ----------------------------------------------------------------------------
// tuple_dictionary_id_assigner_unit
// Assigns dense ids to category tuples through a linear-probe hash table.
// ----------------------------------------------------------------------------
// sequence: a null item goes from key capture to done; otherwise the hash
//   steps and slot reduction run, then each probe slot is a memory read,
//   then a compare; a size that is not a power of two adds slot remainder steps
// throughput: one request at a time, busy until the result is issued
// reset: a clearing pass writes every table slot after reset, busy high
// results are strobed for one cycle on done; the receiver cannot stall
module tuple_dictionary_id_assigner_unit #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int MAX_LAYERS    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tda_pkg::cat_in_t cat,
	output logic             done,
	output tda_pkg::id_out_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [2:0]       cfg_data
);

	tda_pkg::cmd_t    cmd;
	tda_pkg::status_t status;

	tda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	tda_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_LAYERS    (MAX_LAYERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cat       (cat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule
